/* rtl/gve_pkg.sv */
// shared types and constants for the group varint encoder
`timescale 1ns / 1ps
`default_nettype none

package gve_pkg;

	localparam int VALUE_W   = 32;
	localparam int BYTE_W    = 8;
	localparam int CODE_W    = 2;
	localparam int NUM_LANES = 4;
	localparam int LANE_W    = $clog2(NUM_LANES);
	localparam int BSEL_W    = $clog2(VALUE_W / BYTE_W);

	// one value together with its length code (bytes minus one)
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CODE_W-1:0]  code;
	} gve_lane_t;

endpackage

`default_nettype wire

/* rtl/gve_lane.sv */
// one lane: finds the byte length code of a single value
`timescale 1ns / 1ps
`default_nettype none

module gve_lane
	import gve_pkg::*;
(
	input  wire logic [VALUE_W-1:0] value,
	output gve_lane_t               lane
);

	logic [CODE_W-1:0] code;

	// fewest bytes that hold the value, zero takes one byte
	always_comb begin
		if (value[31:24] != 8'd0) begin
			code = 2'd3;
		end else if (value[23:16] != 8'd0) begin
			code = 2'd2;
		end else if (value[15:8] != 8'd0) begin
			code = 2'd1;
		end else begin
			code = 2'd0;
		end
	end

	assign lane.value = value;
	assign lane.code  = code;

endmodule

`default_nettype wire

/* rtl/gve_serializer.sv */
// merge stage: builds the header and walks the lanes out one byte per cycle
`timescale 1ns / 1ps
`default_nettype none

module gve_serializer
	import gve_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load_valid,
	input  wire gve_lane_t [NUM_LANES-1:0] load_lanes,
	output logic                       load_ready,
	output logic                       strobe,
	output logic [BYTE_W-1:0]          out_byte,
	output logic                       is_last
);

	gve_lane_t [NUM_LANES-1:0] lanes_q;
	logic [BYTE_W-1:0]         hdr_q;
	logic                      active_q;
	logic                      hdr_phase_q;
	logic [LANE_W-1:0]         lane_q;
	logic [BSEL_W-1:0]         bidx_q;

	logic [BYTE_W-1:0]  hdr_next;
	logic [VALUE_W-1:0] shifted;
	logic               lane_end;
	logic               last;
	logic               load;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			hdr_next[i*CODE_W +: CODE_W] = load_lanes[i].code;
		end
	end

	assign shifted  = lanes_q[lane_q].value >> {bidx_q, 3'd0};
	assign lane_end = (bidx_q == lanes_q[lane_q].code);
	assign last     = active_q && !hdr_phase_q && (lane_q == '0) && lane_end;

	assign load       = load_valid && (!active_q || last);
	assign load_ready = !active_q || last;

	assign strobe   = active_q;
	assign out_byte = hdr_phase_q ? hdr_q : shifted[BYTE_W-1:0];
	assign is_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			hdr_phase_q <= 1'b0;
			lane_q      <= '0;
			bidx_q      <= '0;
		end else if (load) begin
			active_q    <= 1'b1;
			hdr_phase_q <= 1'b1;
			lane_q      <= LANE_W'(NUM_LANES - 1);
			bidx_q      <= '0;
		end else if (last) begin
			active_q    <= 1'b0;
			hdr_phase_q <= 1'b0;
		end else if (active_q) begin
			if (hdr_phase_q) begin
				hdr_phase_q <= 1'b0;
				lane_q      <= LANE_W'(NUM_LANES - 1);
				bidx_q      <= '0;
			end else if (lane_end) begin
				lane_q <= lane_q - LANE_W'(1);
				bidx_q <= '0;
			end else begin
				bidx_q <= bidx_q + BSEL_W'(1);
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			lanes_q <= load_lanes;
			hdr_q   <= hdr_next;
		end
	end

endmodule

`default_nettype wire

/* rtl/group_varint_encoder_core.sv */
// top level of the group varint encoder
`timescale 1ns / 1ps
`default_nettype none

// group varint encoder
// - input: an item of four unsigned 32-bit values (value_0..value_3) is taken
//   at a rising edge where start is high and busy is low
// - four lanes find each value's byte length (1 to 4, zero takes one byte);
//   their results are registered in stage s1
// - the serializer merges the lanes: a header byte with length-minus-one of
//   value i at bits 2i+1..2i, then the significant bytes of value_3, value_2,
//   value_1, value_0, each least significant byte first
// - output: one byte per cycle on out_byte, marked by strobe; is_last flags
//   the final byte of an item's stream
// - the item passes from s1 into the serializer, which puts the header on
//   out_byte once it is free; s1 can hold the next item meanwhile
// - the byte-wide output sends one item at a time; the next item's header
//   follows the last byte directly when s1 already holds that item
// - busy rises only when s1 holds an item the serializer cannot yet load
// - the receiver cannot stall: every strobed byte is taken that cycle
// - reset clears all control state; no item is in flight afterwards
module group_varint_encoder_core
	import gve_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [VALUE_W-1:0] value_0,
	input  wire logic [VALUE_W-1:0] value_1,
	input  wire logic [VALUE_W-1:0] value_2,
	input  wire logic [VALUE_W-1:0] value_3,
	output logic                    strobe,
	output logic [BYTE_W-1:0]       out_byte,
	output logic                    is_last
);

	logic [NUM_LANES-1:0][VALUE_W-1:0] values;
	gve_lane_t [NUM_LANES-1:0]         lanes;
	gve_lane_t [NUM_LANES-1:0]         lanes_s1;
	logic                              valid_s1;
	logic                              ser_ready;
	logic                              accept;

	assign values = {value_3, value_2, value_1, value_0};

	// length lanes, one per value
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		gve_lane u_lane (
			.value (values[i]),
			.lane  (lanes[i])
		);
	end

	// s1 is free when empty or handing its item over this cycle
	assign busy   = valid_s1 && !ser_ready;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ser_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_s1 <= lanes;
		end
	end

	// merge stage and byte output
	gve_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_lanes (lanes_s1),
		.load_ready (ser_ready),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.is_last    (is_last)
	);

endmodule

`default_nettype wire
